@@ rtl/stpq_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment tree package
// Shared sizes, codes, types and the merge function of the segment tree block.
// ----------------------------------------------------------------------------
package stpq_pkg;

    localparam int SIZE       = 128;
    localparam int NODE_COUNT = 2 * SIZE;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = $clog2(NODE_COUNT);
    localparam int POS_W      = $clog2(SIZE);
    localparam int CNT_W      = POS_W + 1;
    localparam int Q_W        = POS_W + 2;
    // Deepest path below the root, and the pointer and index widths of the walk stacks.
    localparam int DEPTH      = POS_W;
    localparam int SP_W       = $clog2(DEPTH + 1);
    localparam int LVL_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int S_TDATA_W  = 3 * DATA_W;
    localparam int M_TDATA_W  = DATA_W;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_MERGE_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IDENTITY   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LAST       = 2'd3;

    localparam logic [DATA_W-1:0] LAST_RESET = 32'd127;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;
    localparam logic MODE_SUM   = 1'b0;
    localparam logic MODE_MAX   = 1'b1;

    typedef struct packed {
        logic              merge_mode;
        logic [DATA_W-1:0] identity;
        logic [DATA_W-1:0] cover_lo;
        logic              cover_valid;
        logic [POS_W-1:0]  last_idx;
        logic              rebuild;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
    } node_t;

    function automatic logic [DATA_W-1:0] merge2(input logic mode,
                                                 input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] res;
        if (mode == MODE_MAX) begin
            res = ($signed(a) >= $signed(b)) ? a : b;
        end else begin
            res = a + b;
        end
        return res;
    endfunction

endpackage

@@ rtl/stpq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/stpq_cfg.sv @@
// ----------------------------------------------------------------------------
// Segment tree configuration
// Holds the registers and works out the covered span after every write.
// ----------------------------------------------------------------------------
module stpq_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [stpq_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [stpq_pkg::DATA_W-1:0]        cfg_wdata,
    output stpq_pkg::cfg_t                     cfg
);
    import stpq_pkg::*;

    localparam logic signed [DATA_W:0] SPAN_MAX = (DATA_W + 1)'(SIZE - 1);

    logic              mode_reg, mode_next;
    logic [DATA_W-1:0] identity_reg, identity_next;
    logic [DATA_W-1:0] first_reg, first_next;
    logic [DATA_W-1:0] last_reg, last_next;
    logic              dirty_reg, dirty_next;
    logic              cover_valid_reg, cover_valid_next;
    logic [POS_W-1:0]  last_idx_reg, last_idx_next;
    logic signed [DATA_W:0] diff;

    assign diff = signed'({last_reg[DATA_W-1], last_reg}) - signed'({first_reg[DATA_W-1], first_reg});

    always_comb begin
        mode_next        = mode_reg;
        identity_next    = identity_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        dirty_next       = 1'b0;
        cover_valid_next = cover_valid_reg;
        last_idx_next    = last_idx_reg;
        // The span is worked out from the registered bounds once the dirty flag
        // is set; a span wider than the tree is cut to the tree's size.
        if (dirty_reg) begin
            cover_valid_next = !diff[DATA_W];
            last_idx_next    = (diff >= SPAN_MAX) ? POS_W'(SIZE - 1) : diff[POS_W-1:0];
        end
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MERGE_MODE: begin
                    mode_next  = cfg_wdata[0];
                    dirty_next = 1'b1;
                end
                REG_IDENTITY: begin
                    identity_next = cfg_wdata;
                    dirty_next    = 1'b1;
                end
                REG_FIRST: begin
                    first_next = cfg_wdata;
                    dirty_next = 1'b1;
                end
                REG_LAST: begin
                    last_next  = cfg_wdata;
                    dirty_next = 1'b1;
                end
                default: begin
                    dirty_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_SUM;
            identity_reg    <= '0;
            first_reg       <= '0;
            last_reg        <= LAST_RESET;
            dirty_reg       <= 1'b1;
            cover_valid_reg <= 1'b0;
            last_idx_reg    <= '0;
        end else begin
            mode_reg        <= mode_next;
            identity_reg    <= identity_next;
            first_reg       <= first_next;
            last_reg        <= last_next;
            dirty_reg       <= dirty_next;
            cover_valid_reg <= cover_valid_next;
            last_idx_reg    <= last_idx_next;
        end
    end

    assign cfg.merge_mode  = mode_reg;
    assign cfg.identity    = identity_reg;
    assign cfg.cover_lo    = first_reg;
    assign cfg.cover_valid = cover_valid_reg;
    assign cfg.last_idx    = last_idx_reg;
    assign cfg.rebuild     = dirty_reg;

endmodule

@@ rtl/stpq_engine.sv @@
// ----------------------------------------------------------------------------
// Segment tree engine
// Walks the node store for point writes and range queries, one word at a time.
// ----------------------------------------------------------------------------
module stpq_engine (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  stpq_pkg::cfg_t                   cfg,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [stpq_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [stpq_pkg::M_TDATA_W-1:0]   m_tdata
);
    import stpq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_CLAMP  = 3'd2;
    localparam logic [2:0] S_WDOWN  = 3'd3;
    localparam logic [2:0] S_WUP    = 3'd4;
    localparam logic [2:0] S_QWALK  = 3'd5;
    localparam logic [2:0] S_QDRAIN = 3'd6;
    localparam logic [2:0] S_QOUT   = 3'd7;

    logic [2:0]              state_reg, state_next;
    logic                    func_reg, func_next;
    logic [DATA_W-1:0]       plo_reg, plo_next;
    logic [DATA_W-1:0]       phi_reg, phi_next;
    logic [DATA_W-1:0]       val_reg, val_next;
    logic signed [DATA_W:0]  rel_lo_reg, rel_lo_next;
    logic signed [DATA_W:0]  rel_hi_reg, rel_hi_next;
    logic                    rev_reg, rev_next;
    logic signed [Q_W-1:0]   ql_reg, ql_next;
    logic signed [Q_W-1:0]   qh_reg, qh_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [ADDR_W-1:0]       cur_idx_reg, cur_idx_next;
    logic [POS_W-1:0]        cur_lo_reg, cur_lo_next;
    logic [POS_W-1:0]        cur_hi_reg, cur_hi_next;
    logic [DATA_W-1:0]       cur_val_reg, cur_val_next;
    logic [SP_W-1:0]         sp_reg, sp_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic                    rd_mem_reg, rd_mem_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic [DATA_W-1:0]       rd_dflt_reg, rd_dflt_next;
    logic [LVL_W-1:0]        cap_lvl_reg, cap_lvl_next;
    logic [DATA_W-1:0]       acc_reg, acc_next;
    logic                    acc_first_reg, acc_first_next;
    logic                    out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]       out_data_reg, out_data_next;
    logic [NODE_COUNT-1:0]   nvalid_reg, nvalid_next;

    node_t                   qstk_reg [DEPTH];
    logic [ADDR_W-1:0]       wpath_reg [DEPTH];
    logic [DATA_W-1:0]       wsib_reg [DEPTH];
    logic                    qstk_we, wpath_we, wsib_we;
    node_t                   qstk_wdata;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [DATA_W-1:0]       ram_wdata, ram_rdata;

    logic [CNT_W-1:0]        cur_cnt, left_cnt, right_cnt, dflt_cnt;
    logic [POS_W-1:0]        half, mid, mid_up;
    logic [ADDR_W-1:0]       left_idx, right_idx;
    logic                    cur_leaf, go_left;
    logic signed [Q_W-1:0]   lo_q, hi_q, n_q;
    logic signed [DATA_W:0]  last_ext;
    logic                    outside, enclosed, wr_in_range;
    logic [DATA_W-1:0]       dflt_value, rd_value, merged;
    logic [SP_W-1:0]         sp_dec;
    logic [LVL_W-1:0]        lvl_top, lvl_cur;

    stpq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NODE_COUNT)
    ) u_nodes (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Child geometry of the node under the walk (pre-order layout).
    assign cur_cnt   = {1'b0, cur_hi_reg} - {1'b0, cur_lo_reg} + CNT_W'(1);
    assign half      = (cur_hi_reg - cur_lo_reg) >> 1;
    assign mid       = cur_lo_reg + half;
    assign mid_up    = mid + POS_W'(1);
    assign left_cnt  = {1'b0, half} + CNT_W'(1);
    assign right_cnt = cur_cnt - left_cnt;
    assign left_idx  = cur_idx_reg + ADDR_W'(1);
    assign right_idx = cur_idx_reg + ADDR_W'({left_cnt, 1'b0});
    assign cur_leaf  = (cur_lo_reg == cur_hi_reg);
    assign go_left   = (pos_reg <= mid);

    assign lo_q     = signed'({2'b00, cur_lo_reg});
    assign hi_q     = signed'({2'b00, cur_hi_reg});
    assign n_q      = signed'({2'b00, cfg.last_idx}) + Q_W'(1);
    assign last_ext = signed'({{(DATA_W + 1 - POS_W){1'b0}}, cfg.last_idx});
    assign outside  = (qh_reg < lo_q) || (ql_reg > hi_q);
    assign enclosed = (ql_reg <= lo_q) && (hi_q <= qh_reg);
    assign wr_in_range = cfg.cover_valid && !rel_lo_reg[DATA_W] && (rel_lo_reg <= last_ext);

    assign sp_dec  = sp_reg - SP_W'(1);
    assign lvl_top = sp_dec[LVL_W-1:0];
    assign lvl_cur = sp_reg[LVL_W-1:0];

    // A node never written since the last rebuild holds what the rebuild left:
    // the identity, summed once for every leaf below it in sum mode.
    assign dflt_value = (cfg.merge_mode == MODE_MAX) ? cfg.identity
                                                      : cfg.identity * DATA_W'(dflt_cnt);
    assign rd_value   = (rd_mem_reg && rd_valid_reg) ? ram_rdata : rd_dflt_reg;
    assign merged     = merge2(cfg.merge_mode, cur_val_reg, wsib_reg[lvl_top]);

    assign s_tready = (state_reg == S_IDLE) && !cfg.rebuild;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        val_next       = val_reg;
        rel_lo_next    = rel_lo_reg;
        rel_hi_next    = rel_hi_reg;
        rev_next       = rev_reg;
        ql_next        = ql_reg;
        qh_next        = qh_reg;
        pos_next       = pos_reg;
        cur_idx_next   = cur_idx_reg;
        cur_lo_next    = cur_lo_reg;
        cur_hi_next    = cur_hi_reg;
        cur_val_next   = cur_val_reg;
        sp_next        = sp_reg;
        rd_pend_next   = 1'b0;
        rd_mem_next    = rd_mem_reg;
        rd_valid_next  = rd_valid_reg;
        rd_dflt_next   = rd_dflt_reg;
        cap_lvl_next   = cap_lvl_reg;
        acc_next       = acc_reg;
        acc_first_next = acc_first_reg;
        out_data_next  = out_data_reg;
        out_valid_next = (out_valid_reg && m_tready) ? 1'b0 : out_valid_reg;
        nvalid_next    = nvalid_reg;
        qstk_we        = 1'b0;
        qstk_wdata     = '{idx: right_idx, lo: mid_up, hi: cur_hi_reg};
        wpath_we       = 1'b0;
        wsib_we        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cur_idx_reg;
        ram_wdata      = val_reg;
        ram_raddr      = cur_idx_reg;
        dflt_cnt       = cur_cnt;

        // A read issued last cycle lands here: a sibling for the write path,
        // or one more piece of the query result.
        if (rd_pend_reg) begin
            if (func_reg == FUNC_QUERY) begin
                acc_next       = acc_first_reg ? rd_value
                                               : merge2(cfg.merge_mode, acc_reg, rd_value);
                acc_first_next = 1'b0;
            end else begin
                wsib_we = 1'b1;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    func_next  = s_tuser;
                    plo_next   = s_tdata[DATA_W-1:0];
                    phi_next   = s_tdata[2*DATA_W-1:DATA_W];
                    val_next   = s_tdata[3*DATA_W-1:2*DATA_W];
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                rel_lo_next = signed'({plo_reg[DATA_W-1], plo_reg})
                            - signed'({cfg.cover_lo[DATA_W-1], cfg.cover_lo});
                rel_hi_next = signed'({phi_reg[DATA_W-1], phi_reg})
                            - signed'({cfg.cover_lo[DATA_W-1], cfg.cover_lo});
                rev_next    = $signed(plo_reg) > $signed(phi_reg);
                state_next  = S_CLAMP;
            end
            S_CLAMP: begin
                cur_idx_next   = '0;
                cur_lo_next    = '0;
                cur_hi_next    = cfg.last_idx;
                sp_next        = '0;
                acc_first_next = 1'b1;
                if (func_reg == FUNC_WRITE) begin
                    pos_next   = rel_lo_reg[POS_W-1:0];
                    state_next = wr_in_range ? S_WDOWN : S_IDLE;
                end else if (rev_reg || !cfg.cover_valid) begin
                    acc_next   = cfg.identity;
                    state_next = S_QOUT;
                end else begin
                    // The low bound is clamped into the span or one past it, the high bound into
                    // the span or one before it, which keeps every node comparison unchanged.
                    if (rel_lo_reg[DATA_W]) begin
                        ql_next = '0;
                    end else if (rel_lo_reg > last_ext) begin
                        ql_next = n_q;
                    end else begin
                        ql_next = signed'(rel_lo_reg[Q_W-1:0]);
                    end
                    if (rel_hi_reg[DATA_W]) begin
                        qh_next = '1;
                    end else if (rel_hi_reg > last_ext) begin
                        qh_next = signed'({2'b00, cfg.last_idx});
                    end else begin
                        qh_next = signed'(rel_hi_reg[Q_W-1:0]);
                    end
                    state_next = S_QWALK;
                end
            end
            S_WDOWN: begin
                if (cur_leaf) begin
                    ram_we       = 1'b1;
                    ram_waddr    = cur_idx_reg;
                    ram_wdata    = val_reg;
                    cur_val_next = val_reg;
                    state_next   = S_WUP;
                end else begin
                    wpath_we      = 1'b1;
                    ram_raddr     = go_left ? right_idx : left_idx;
                    dflt_cnt      = go_left ? right_cnt : left_cnt;
                    rd_pend_next  = 1'b1;
                    rd_mem_next   = 1'b1;
                    rd_valid_next = nvalid_reg[ram_raddr];
                    rd_dflt_next  = dflt_value;
                    cap_lvl_next  = lvl_cur;
                    sp_next       = sp_reg + SP_W'(1);
                    if (go_left) begin
                        cur_idx_next = left_idx;
                        cur_hi_next  = mid;
                    end else begin
                        cur_idx_next = right_idx;
                        cur_lo_next  = mid_up;
                    end
                end
            end
            S_WUP: begin
                if (sp_reg == '0) begin
                    state_next = S_IDLE;
                end else begin
                    ram_we       = 1'b1;
                    ram_waddr    = wpath_reg[lvl_top];
                    ram_wdata    = merged;
                    cur_val_next = merged;
                    sp_next      = sp_dec;
                end
            end
            S_QWALK: begin
                if (outside || enclosed) begin
                    // Each finished node feeds exactly one piece through the read slot.
                    rd_pend_next  = 1'b1;
                    rd_mem_next   = enclosed;
                    rd_valid_next = nvalid_reg[cur_idx_reg];
                    rd_dflt_next  = enclosed ? dflt_value : cfg.identity;
                    if (sp_reg != '0) begin
                        cur_idx_next = qstk_reg[lvl_top].idx;
                        cur_lo_next  = qstk_reg[lvl_top].lo;
                        cur_hi_next  = qstk_reg[lvl_top].hi;
                        sp_next      = sp_dec;
                    end else begin
                        state_next = S_QDRAIN;
                    end
                end else begin
                    qstk_we      = 1'b1;
                    sp_next      = sp_reg + SP_W'(1);
                    cur_idx_next = left_idx;
                    cur_hi_next  = mid;
                end
            end
            S_QDRAIN: begin
                state_next = S_QOUT;
            end
            S_QOUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.rebuild) begin
            nvalid_next = '0;
        end else if (ram_we) begin
            nvalid_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            nvalid_reg    <= '0;
            sp_reg        <= '0;
        end else begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            nvalid_reg    <= nvalid_next;
            sp_reg        <= sp_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        plo_reg       <= plo_next;
        phi_reg       <= phi_next;
        val_reg       <= val_next;
        rel_lo_reg    <= rel_lo_next;
        rel_hi_reg    <= rel_hi_next;
        rev_reg       <= rev_next;
        ql_reg        <= ql_next;
        qh_reg        <= qh_next;
        pos_reg       <= pos_next;
        cur_idx_reg   <= cur_idx_next;
        cur_lo_reg    <= cur_lo_next;
        cur_hi_reg    <= cur_hi_next;
        cur_val_reg   <= cur_val_next;
        rd_mem_reg    <= rd_mem_next;
        rd_valid_reg  <= rd_valid_next;
        rd_dflt_reg   <= rd_dflt_next;
        cap_lvl_reg   <= cap_lvl_next;
        acc_reg       <= acc_next;
        acc_first_reg <= acc_first_next;
        out_data_reg  <= out_data_next;
        if (qstk_we) begin
            qstk_reg[lvl_cur] <= qstk_wdata;
        end
        if (wpath_we) begin
            wpath_reg[lvl_cur] <= cur_idx_reg;
        end
        if (wsib_we) begin
            wsib_reg[cap_lvl_reg] <= rd_value;
        end
    end

endmodule

@@ rtl/segment_tree_point_update_range_query.sv @@
// Write word: set-up states PREP and CLAMP, then WDOWN down the path and WUP back up
// (tree depth 7 for 128 positions), bounded by the single node store port.
// Query word: PREP and CLAMP, QWALK over the visited nodes, then QDRAIN and QOUT to
// the output register; the next word is taken while the result waits.
// Reset is synchronous and active low: the control registers take their reset
// values; s_tready is low while the span is recomputed after reset or a config write.
// ----------------------------------------------------------------------------
// Segment tree with point write and range query
// Stream front end over the configuration block and the node store engine.
// ----------------------------------------------------------------------------
module segment_tree_point_update_range_query (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [stpq_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [stpq_pkg::DATA_W-1:0]        cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // position_low, position_high, write_value
    input  logic [stpq_pkg::S_TDATA_W-1:0]     s_tdata,
    // func
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // query_result
    output logic [stpq_pkg::M_TDATA_W-1:0]     m_tdata
);
    import stpq_pkg::*;

    cfg_t cfg;

    stpq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    stpq_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ rtl/stpq_checker.sv @@
// ----------------------------------------------------------------------------
// Segment tree port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module stpq_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             cfg_wr_en,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [stpq_pkg::M_TDATA_W-1:0]   m_tdata
);

    // A result that is not taken stays as it is.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed or dropped");

    // The span is recomputed after a configuration write before any word is taken.
    a_cfg_block: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("input taken while span is recomputed");

    // Words are handled one at a time.
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken straight after the first");

    // No result can appear in the cycle after a word is taken.
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared without a finished query");

endmodule

bind segment_tree_point_update_range_query stpq_checker u_stpq_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_wr_en (cfg_wr_en),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
